>>> src/tet_pkg.sv
`default_nettype none
package tet_pkg;
   localparam int ROWS = 60;
   localparam int COLS = 80;
   localparam int TRACK_WINDOW = 4;
   localparam int MAX_RESULTS = 59;
   localparam int PIXELS = ROWS * COLS;
   localparam int AW = $clog2(PIXELS);
   localparam int RW = $clog2(ROWS);
   localparam int CW = 9;
   localparam int IW = $clog2(TRACK_WINDOW + 1);
   localparam int LO_ROW = (ROWS - MAX_RESULTS < 1) ? 1 : ROWS - MAX_RESULTS;

   localparam logic [0:0] REG_TOP_ROW = 1'd0;
   localparam logic [0:0] REG_START_COLUMN = 1'd1;

   typedef enum logic [4:0] {
      ST_LOAD, ST_CLEAR, ST_SIDE,
      ST_SCAN_A, ST_SCAN_B, ST_SCAN_C, ST_SCAN_D, ST_SCAN_E, ST_SCAN_F,
      ST_TR_ROW, ST_TR_A, ST_TR_B, ST_TR_C, ST_TR_D,
      ST_TR_E, ST_TR_F, ST_TR_G, ST_TR_H, ST_TR_W1, ST_TR_W2,
      ST_OUT_A, ST_OUT_B, ST_OUT_C
   } state_type;

   typedef struct packed {
      logic signed [7:0] left_edge;
      logic signed [7:0] right_edge;
      logic [RW-1:0] row_index;
   } row_type;
endpackage
`default_nettype wire

>>> src/tet_chan_if.sv
`default_nettype none
interface tet_req_if;
   logic valid;
   logic ready;
   logic pixel;
   logic frame_start;
   modport source (output valid, pixel, frame_start, input ready);
   modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface tet_rsp_if;
   logic valid;
   logic ready;
   logic [5:0] row_index;
   logic signed [7:0] left_edge;
   logic signed [7:0] right_edge;
   logic signed [7:0] mid_column;
   logic mid_valid;
   logic last_row;
   modport source (output valid, row_index, left_edge, right_edge, mid_column,
                   mid_valid, last_row, input ready);
   modport sink (input valid, row_index, left_edge, right_edge, mid_column,
                 mid_valid, last_row, output ready);
endinterface
`default_nettype wire

>>> src/track_edge_tracker_core.sv
// Track edge tracker core.
// req channel: one binary pixel per word, row-major, frame_start forces the
// word to frame position 0; each accepted pixel goes into the frame memory.
// After the last pixel of a frame req.ready drops and the sequencer walks the
// stored frame through one frame-memory read port with a registered read:
// it clears all 60 rows of the edge tables, then for each side scans columns
// and traces rows upward along the edge, walking along black runs. The walk's
// length depends on the image and top_row.
// rsp channel: afterward one word per row from top_row, clamped to 1..58, to
// the bottom row, carrying edges, midline and a last_row flag on the bottom
// row. req.ready returns the cycle after the bottom row word.
// A stalled rsp receiver holds the current word and stops the sequencer.
// Reset zeroes the pixel position and restores top_row 10 and start_column 39.
// The frame memory and edge tables are not cleared; the tables are cleared at
// the start of every walk. top_row is taken with the last pixel, start_column
// during the walk: write csr only while no frame is being walked.
`default_nettype none
module track_edge_tracker_core
   import tet_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   tet_req_if.sink         req,
   tet_rsp_if.source       rsp,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [6:0] csr_data
);
   typedef logic signed [CW-1:0] sv_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0] top_reg_ff;
   logic [6:0] start_reg_ff;
   logic [AW-1:0] pos_ff;
   sv_type r_ff, r_in, c_ff, c_in, top_ff, top_in;
   sv_type pr_ff, pr_in, pc_ff, pc_in;
   logic [1:0] a_ff, a_in;
   logic [IW-1:0] i_ff, i_in;
   logic side_ff, side_in;
   logic [RW:0] clr_ff, clr_in;
   logic signed [7:0] le_mem [ROWS];
   logic signed [7:0] re_mem [ROWS];
   logic e_we;
   logic [RW-1:0] e_row;
   logic signed [7:0] e_val;
   logic e_side;
   logic signed [7:0] lo_ff, ro_ff;
   logic [1:0] code;
   sv_type dir;
   logic [AW-1:0] wpos;
   logic last_px;

   assign dir = side_ff ? sv_type'(1) : sv_type'(-1);
   assign wpos = req.frame_start ? '0 : pos_ff;
   assign last_px = wpos == AW'(PIXELS - 1);
   assign req.ready = state_ff == ST_LOAD;

   tet_pix_unit u_pix (.clock, .wr_en(req.valid && req.ready), .wr_addr(wpos),
                       .wr_data(req.pixel), .row(pr_ff), .col(pc_ff), .code);

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      r_in = r_ff; c_in = c_ff; top_in = top_ff;
      pr_in = pr_ff; pc_in = pc_ff; a_in = a_ff; i_in = i_ff;
      side_in = side_ff; clr_in = clr_ff;
      e_we = 1'b0; e_row = r_ff[RW-1:0]; e_val = c_ff[7:0]; e_side = side_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req.valid && last_px) begin
               top_in = sv_type'(top_reg_ff);
               if (top_reg_ff < LO_ROW) top_in = sv_type'(LO_ROW);
               if (top_reg_ff > ROWS - 2) top_in = sv_type'(ROWS - 2);
               clr_in = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            e_we = 1'b1; e_row = clr_ff[RW-1:0]; e_val = -8'sd1; e_side = 1'b0;
            clr_in = clr_ff + 1'b1;
            side_in = 1'b0;
            if (clr_ff == (RW+1)'(ROWS - 1)) begin
               r_in = sv_type'(ROWS - 1);
               state_in = ST_SIDE;
            end
         end
         ST_SIDE: begin
            // side loop head: hold r_ff as the current row
            if (r_ff > top_ff) begin
               c_in = (start_reg_ff > COLS - 1) ? sv_type'(COLS - 1)
                                               : sv_type'(start_reg_ff);
               state_in = ST_SCAN_A;
            end else if (!side_ff) begin
               side_in = 1'b1; r_in = sv_type'(ROWS - 1);
            end else begin
               r_in = top_ff; state_in = ST_OUT_A;
            end
         end
         ST_SCAN_A: begin
            if (c_ff >= 0 && c_ff < COLS) begin
               pr_in = r_ff; pc_in = c_ff; state_in = ST_SCAN_B;
            end else if (c_ff == (side_ff ? sv_type'(COLS) : sv_type'(-1))) begin
               e_we = 1'b1; e_val = -8'sd1;
               r_in = r_ff - sv_type'(1); state_in = ST_SIDE;
            end else begin
               state_in = ST_SCAN_E;
            end
         end
         ST_SCAN_B: begin
            pc_in = c_ff - dir; state_in = ST_SCAN_C;
         end
         ST_SCAN_C: begin
            if (code != 2'd0) begin
               c_in = c_ff + dir; state_in = ST_SCAN_A;
            end else begin
               pr_in = r_ff + sv_type'(1); pc_in = c_ff; state_in = ST_SCAN_D;
            end
         end
         ST_SCAN_D: begin
            if (code != 2'd1) begin
               c_in = c_ff + dir; state_in = ST_SCAN_A;
            end else if (r_ff >= ROWS - 1) begin
               state_in = ST_SCAN_E;
            end else begin
               a_in = 2'd0; pr_in = r_ff - sv_type'(1); state_in = ST_TR_W1;
               ret_in = ST_SCAN_D;
            end
         end
         ST_SCAN_E: begin
            e_we = 1'b1;
            r_in = r_ff - sv_type'(1); state_in = ST_TR_ROW;
         end
         ST_SCAN_F: begin
            if (code == 2'd0) begin
               state_in = ST_SCAN_E;
            end else begin
               c_in = c_ff + dir; state_in = ST_SCAN_A;
            end
         end
         ST_TR_ROW: begin
            if (r_ff > top_ff && c_ff < COLS && c_ff >= 0) begin
               i_in = '0; state_in = ST_TR_A;
            end else begin
               state_in = side_ff ? ST_OUT_A : ST_SIDE;
               if (!side_ff) begin
                  side_in = 1'b1; r_in = sv_type'(ROWS - 1);
               end else begin
                  r_in = top_ff;
               end
            end
         end
         ST_TR_A: begin
            if (i_ff == IW'(TRACK_WINDOW)) begin
               pr_in = r_ff; pc_in = c_ff; state_in = ST_TR_G; ret_in = ST_TR_G;
            end else begin
               pr_in = r_ff; pc_in = c_ff + sv_type'(i_ff); state_in = ST_TR_B;
            end
         end
         ST_TR_B: begin
            pc_in = c_ff + sv_type'(i_ff) - dir; state_in = ST_TR_C;
         end
         ST_TR_C: begin
            a_in = code; state_in = ST_TR_D;
         end
         ST_TR_D: begin
            if (a_ff == 2'd0 && code == 2'd1) begin
               c_in = c_ff + sv_type'(i_ff); state_in = ST_TR_H;
            end else begin
               pc_in = c_ff - sv_type'(i_ff); state_in = ST_TR_E;
            end
         end
         ST_TR_E: begin
            pc_in = c_ff - sv_type'(i_ff) - dir; state_in = ST_TR_F;
         end
         ST_TR_F: begin
            a_in = code; state_in = ST_TR_W2;
         end
         ST_TR_W2: begin
            if (a_ff == 2'd0 && code == 2'd1) begin
               c_in = c_ff - sv_type'(i_ff); state_in = ST_TR_H;
            end else begin
               i_in = i_ff + 1'b1; state_in = ST_TR_A;
            end
         end
         ST_TR_G: begin
            // wait for the registered read, then decide gap or walk
            state_in = ST_TR_W1;
         end
         ST_TR_W1: begin
            if (ret_ff == ST_SCAN_D) begin
               state_in = (code == 2'd0) ? ST_SCAN_E : ST_SCAN_F;
            end else if (ret_ff == ST_TR_G && code == 2'd1) begin
               state_in = ST_SIDE;
            end else if (code == 2'd0 && c_ff < COLS && c_ff >= 0) begin
               c_in = c_ff - dir; pc_in = c_ff - dir;
               state_in = ST_TR_G; ret_in = ST_TR_W1;
            end else begin
               state_in = ST_TR_H;
            end
         end
         ST_TR_H: begin
            e_we = 1'b1; r_in = r_ff - sv_type'(1); state_in = ST_TR_ROW;
         end
         ST_OUT_A: state_in = ST_OUT_B;
         ST_OUT_B: state_in = ST_OUT_C;
         ST_OUT_C: begin
            if (rsp.ready) begin
               if (r_ff == sv_type'(ROWS - 1)) state_in = ST_LOAD;
               else begin
                  r_in = r_ff + sv_type'(1); state_in = ST_OUT_A;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // compare after gap-walk probe: on TR_G the probe column tracks c
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ret_ff <= ST_LOAD;
         pos_ff <= '0;
         top_reg_ff <= 6'd10;
         start_reg_ff <= 7'd39;
         clr_ff <= '0;
         side_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         clr_ff <= clr_in;
         side_ff <= side_in;
         if (req.valid && req.ready) pos_ff <= last_px ? '0 : wpos + 1'b1;
         if (csr_write && csr_index == REG_TOP_ROW) top_reg_ff <= csr_data[5:0];
         if (csr_write && csr_index == REG_START_COLUMN) start_reg_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; c_ff <= c_in; top_ff <= top_in;
      pr_ff <= pr_in; pc_ff <= pc_in; a_ff <= a_in; i_ff <= i_in;
      if (e_we && state_ff == ST_CLEAR) begin
         le_mem[e_row] <= e_val; re_mem[e_row] <= e_val;
      end else if (e_we && !e_side) le_mem[e_row] <= e_val;
      else if (e_we) re_mem[e_row] <= e_val;
      lo_ff <= le_mem[r_ff[RW-1:0]];
      ro_ff <= re_mem[r_ff[RW-1:0]];
   end

   logic signed [7:0] lf, rf;
   logic signed [8:0] half;
   logic [RW:0] rp3;
   always_comb begin
      lf = lo_ff; rf = ro_ff;
      if (lf != -8'sd1 && rf != -8'sd1 && lf > rf) begin
         lf = -8'sd1; rf = -8'sd1;
      end
      rp3 = (RW+1)'(r_ff[RW-1:0]) + (RW+1)'(3);
      half = 9'(rp3 >> 1);
      rsp.mid_valid = 1'b1;
      if (lf == -8'sd1 && rf != -8'sd1) rsp.mid_column = 8'(9'(rf) - half);
      else if (lf != -8'sd1 && rf == -8'sd1) rsp.mid_column = 8'(9'(lf) + half);
      else if (lf != -8'sd1) rsp.mid_column = 8'((9'(lf) + 9'(rf)) / 2);
      else begin
         rsp.mid_column = '0; rsp.mid_valid = 1'b0;
      end
   end
   assign rsp.valid = state_ff == ST_OUT_C;
   assign rsp.row_index = 6'(r_ff[RW-1:0]);
   assign rsp.left_edge = lf;
   assign rsp.right_edge = rf;
   assign rsp.last_row = r_ff == sv_type'(ROWS - 1);
endmodule
`default_nettype wire

>>> src/tet_frame_ram.sv
`default_nettype none
module tet_frame_ram
   import tet_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data
);
   logic mem [PIXELS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/tet_pix_unit.sv
`default_nettype none
module tet_pix_unit
   import tet_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic                 wr_data,
   input  wire logic signed [CW-1:0] row,
   input  wire logic signed [CW-1:0] col,
   output logic [1:0]                code
);
   logic outside_ff, outside_in;
   logic data;
   logic [AW-1:0] addr;
   always_comb begin
      outside_in = (row < 0) || (row >= ROWS) || (col < 0) || (col >= COLS);
      addr = outside_in ? '0 : AW'(row * COLS + col);
   end
   always_ff @(posedge clock) outside_ff <= outside_in;
   tet_frame_ram u_ram (.clock, .wr_en, .wr_addr, .wr_data, .rd_addr(addr),
                        .rd_data(data));
   assign code = outside_ff ? 2'd2 : {1'b0, data};
endmodule
`default_nettype wire

>>> src/tet_port_check.sv
`default_nettype none
module tet_port_check
   import tet_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ok,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ok && rsp_valid)) else $error("req and rsp overlap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid) else $error("extra word");
endmodule

bind track_edge_tracker_core tet_port_check u_check (.clock, .reset,
   .req_ok(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last(rsp.last_row));
`default_nettype wire

>>> tb/sv/tet_track_checker.sv
`timescale 1ns / 100ps
module tet_track_checker
   import tet_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   tet_req_if              req,
   tet_rsp_if              rsp,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [6:0] csr_data,
   output int              fails,
   output int              pending
);
   localparam int PX_BLACK = 0;
   localparam int PX_WHITE = 1;
   localparam int PX_OUTSIDE = 2;

   typedef struct {
      logic [5:0]        row_index;
      logic signed [7:0] left_edge;
      logic signed [7:0] right_edge;
      logic signed [7:0] mid_column;
      logic              mid_valid;
      logic              last_row;
   } row_edges_type;

   row_edges_type row_queue[$];
   bit          frame_mem[PIXELS];
   int unsigned pix_pos;
   int          top_reg;
   int          start_reg;
   int          walk[ROWS];
   int          lft[ROWS];
   int          rgt[ROWS];

   function automatic int px(int r, int c);
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return PX_OUTSIDE;
      return frame_mem[r * COLS + c] ? PX_WHITE : PX_BLACK;
   endfunction

   function automatic int scan_row(int r, int dir, int c0);
      int c;
      bit hit;
      c = c0;
      while (c >= 0 && c < COLS) begin
         hit = px(r, c) == PX_BLACK && px(r, c - dir) == PX_WHITE;
         if (hit && r < ROWS - 1)
            hit = px(r + 1, c) == PX_BLACK || px(r - 1, c) == PX_BLACK;
         if (hit) return c;
         c += dir;
      end
      return c;
   endfunction

   function automatic int trace_up(int r0, int c0, int dir, int top);
      int r;
      int c;
      bit found;
      r = r0 - 1;
      c = c0;
      while (r > top && c < COLS && c >= 0) begin
         found = 0;
         for (int i = 0; i < TRACK_WINDOW; i++) begin
            if (px(r, c + i) == PX_BLACK && px(r, c + i - dir) == PX_WHITE) begin
               c = c + i;
               found = 1;
               break;
            end
            if (px(r, c - i) == PX_BLACK && px(r, c - i - dir) == PX_WHITE) begin
               c = c - i;
               found = 1;
               break;
            end
         end
         if (!found) begin
            if (px(r, c) == PX_WHITE) return r;
            while (px(r, c) == PX_BLACK && c < COLS && c >= 0) c -= dir;
         end
         walk[r] = c;
         r--;
      end
      return 0;
   endfunction

   function automatic void walk_side(int dir, int top, int start);
      int miss;
      int r;
      int c;
      int g;
      miss = dir < 0 ? -1 : COLS;
      for (int i = 0; i < ROWS; i++) walk[i] = -1;
      r = ROWS - 1;
      while (r > top) begin
         c = scan_row(r, dir, start);
         if (c == miss) begin
            walk[r] = -1;
            r--;
         end else begin
            walk[r] = c;
            g = trace_up(r, c, dir, top);
            if (g == 0) break;
            r = g;
         end
      end
   endfunction

   function automatic void predict_rows();
      int top;
      int start;
      int l;
      int rr;
      int mid;
      row_edges_type e;
      top = top_reg;
      if (top < LO_ROW) top = LO_ROW;
      if (top > ROWS - 2) top = ROWS - 2;
      start = start_reg > COLS - 1 ? COLS - 1 : start_reg;
      walk_side(-1, top, start);
      lft = walk;
      walk_side(1, top, start);
      rgt = walk;
      for (int r = top; r < ROWS; r++) begin
         l = lft[r];
         rr = rgt[r];
         mid = 0;
         e.mid_valid = 1;
         if (l != -1 && rr != -1 && l > rr) begin
            l = -1;
            rr = -1;
         end
         if (l == -1 && rr != -1) mid = rr - (r + 3) / 2;
         else if (l != -1 && rr == -1) mid = l + (r + 3) / 2;
         else if (l != -1 && rr != -1) mid = (l + rr) / 2;
         else e.mid_valid = 0;
         e.row_index = r[5:0];
         e.left_edge = l[7:0];
         e.right_edge = rr[7:0];
         e.mid_column = mid[7:0];
         e.last_row = r == ROWS - 1;
         row_queue.push_back(e);
      end
   endfunction

   task automatic report(string field, int row, int got, int want);
      $display("%0t: row %0d %s got %0d expected %0d", $realtime, row, field, got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      row_edges_type e;
      if (reset) begin
         pix_pos = 0;
         top_reg = 10;
         start_reg = 39;
         row_queue.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == REG_TOP_ROW) top_reg = csr_data & 7'h3f;
            else start_reg = csr_data;
         end
         if (req.valid && req.ready) begin
            if (req.frame_start || pix_pos >= PIXELS) pix_pos = 0;
            frame_mem[pix_pos] = req.pixel;
            if (pix_pos == PIXELS - 1) begin
               pix_pos = 0;
               predict_rows();
            end else begin
               pix_pos++;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (row_queue.size() == 0) begin
               report("unexpected word", rsp.row_index, 0, 0);
            end else begin
               e = row_queue.pop_front();
               if (rsp.row_index !== e.row_index)
                  report("row_index", e.row_index, rsp.row_index, e.row_index);
               if (rsp.left_edge !== e.left_edge)
                  report("left_edge", e.row_index, rsp.left_edge, e.left_edge);
               if (rsp.right_edge !== e.right_edge)
                  report("right_edge", e.row_index, rsp.right_edge, e.right_edge);
               if (rsp.mid_valid !== e.mid_valid)
                  report("mid_valid", e.row_index, rsp.mid_valid, e.mid_valid);
               if (e.mid_valid && rsp.mid_column !== e.mid_column)
                  report("mid_column", e.row_index, rsp.mid_column, e.mid_column);
               if (rsp.last_row !== e.last_row)
                  report("last_row", e.row_index, rsp.last_row, e.last_row);
            end
         end
      end
      pending = row_queue.size();
   end
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
   import tet_pkg::*;

   localparam int IDLE_LIMIT = 300000;
   localparam int K_BLACK = 0;
   localparam int K_WHITE = 1;
   localparam int K_TRACK = 2;
   localparam int K_NOISE = 3;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [6:0] csr_data;
   int         fails;
   int         pending;
   int         req_gap_max;
   int         rsp_gap_max;
   int         quiet;

   tet_req_if req_ch ();
   tet_rsp_if rsp_ch ();

   track_edge_tracker_core dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   tet_track_checker checker_i (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fails(fails), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("FAIL track_edge_tracker_core");
         $finish;
      end
   end

   initial begin
      int gap;
      rsp_ch.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ch.ready = 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1;
         #1;
         while (!rsp_ch.valid) begin
            @(negedge clock);
            #1;
         end
         @(negedge clock);
      end
   end

   task automatic send_word(bit pix, bit fs);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.pixel = pix;
      req_ch.frame_start = fs;
      #1;
      while (!req_ch.ready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [6:0] val);
      csr_write = 1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   task automatic send_partial();
      int n;
      n = $urandom_range(1, 600);
      for (int i = 0; i < n; i++) send_word(1'($urandom_range(0, 1)), i == 0);
   endtask

   task automatic send_frame(int kind, bit fs_first);
      int centre;
      int half;
      int noise;
      int lb;
      int rb;
      int row_kind;
      bit pix;
      centre = $urandom_range(15, 65);
      half = $urandom_range(4, 30);
      noise = $urandom_range(0, 4);
      for (int r = 0; r < ROWS; r++) begin
         centre += $urandom_range(0, 4) - 2;
         if (centre < 0) centre = 0;
         if (centre > COLS - 1) centre = COLS - 1;
         half += $urandom_range(0, 2) - 1;
         if (half < 1) half = 1;
         lb = centre - half;
         rb = centre + half;
         row_kind = $urandom_range(0, 29);
         for (int c = 0; c < COLS; c++) begin
            case (kind)
               K_BLACK: pix = 0;
               K_WHITE: pix = 1;
               K_NOISE: pix = 1'($urandom_range(0, 1));
               default: begin
                  if (row_kind == 0) pix = 1;
                  else if (row_kind == 1) pix = 0;
                  else pix = c > lb && c < rb;
                  if ($urandom_range(0, 99) < noise) pix = ~pix;
               end
            endcase
            send_word(pix, (r == 0 && c == 0) ? fs_first : 1'b0);
         end
      end
   endtask

   task automatic pick_idling();
      case ($urandom_range(0, 2))
         0: begin req_gap_max = 0; rsp_gap_max = 0; end
         1: begin req_gap_max = 8; rsp_gap_max = 8; end
         default: begin req_gap_max = 1; rsp_gap_max = 8; end
      endcase
   endtask

   initial begin
      req_gap_max = 0;
      rsp_gap_max = 0;
      req_ch.valid = 0;
      req_ch.pixel = 0;
      req_ch.frame_start = 0;
      csr_write = 0;
      csr_index = REG_TOP_ROW;
      csr_data = 0;
      reset = 1;
      repeat (5) @(negedge clock);
      reset = 0;

      send_frame(K_TRACK, 1);
      drain();
      write_reg(REG_TOP_ROW, 7'd1);
      write_reg(REG_START_COLUMN, 7'd1);
      pick_idling();
      send_frame(K_TRACK, 0);
      drain();
      write_reg(REG_TOP_ROW, 7'd58);
      write_reg(REG_START_COLUMN, 7'd78);
      send_partial();
      send_frame(K_NOISE, 1);
      drain();
      write_reg(REG_TOP_ROW, 7'd0);
      write_reg(REG_START_COLUMN, 7'd0);
      req_gap_max = 8;
      rsp_gap_max = 8;
      send_frame(K_WHITE, 1);
      drain();
      write_reg(REG_TOP_ROW, 7'h3f);
      write_reg(REG_START_COLUMN, 7'h7f);
      pick_idling();
      send_frame(K_BLACK, 1);
      drain();

      for (int f = 0; f < 4; f++) begin
         write_reg(REG_TOP_ROW, 7'($urandom_range(0, 63)));
         write_reg(REG_START_COLUMN, 7'($urandom_range(0, 127)));
         pick_idling();
         if ($urandom_range(0, 2) == 0) send_partial();
         send_frame($urandom_range(0, 5) == 0 ? K_NOISE : K_TRACK,
                    1'($urandom_range(0, 1)));
         drain();
      end

      if (fails == 0 && pending == 0) $display("PASS track_edge_tracker_core");
      else $display("FAIL track_edge_tracker_core");
      $finish;
   end
endmodule
